// ----- rtl/core/blmc_pkg.sv -----
// ----------------------------------------------------------------------------
// blmc_pkg
// Types, codes and reset values for the blink mode controller.
// ----------------------------------------------------------------------------
package blmc_pkg;

	localparam int CODE_LENGTH = 5;
	localparam int INTERVAL_W  = 16;
	localparam int SECRET_W    = 10;
	localparam int KEY_BITS    = 2 * CODE_LENGTH;
	localparam int SECRET_EXT_W = (KEY_BITS > SECRET_W) ? KEY_BITS : SECRET_W;
	localparam int KCNT_W      = $clog2(CODE_LENGTH + 1);
	localparam int CFG_ADDR_W  = 2;

	localparam logic [INTERVAL_W-1:0] SLOW_RESET   = INTERVAL_W'(1000);
	localparam logic [INTERVAL_W-1:0] MID_RESET    = INTERVAL_W'(500);
	localparam logic [INTERVAL_W-1:0] FAST_RESET   = INTERVAL_W'(125);
	localparam logic [SECRET_W-1:0]   SECRET_RESET = SECRET_W'(421);
	localparam logic [INTERVAL_W-1:0] ELAPSED_MAX  = '1;

	localparam logic       CMD_TICK = 1'b0;
	localparam logic [1:0] BTN_ONE  = 2'd1;
	localparam logic [1:0] BTN_TWO  = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_SLOW   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MID    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FAST   = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SECRET = 2'd3;

	localparam logic RET_OFF = 1'b0;
	localparam logic RET_ON  = 1'b1;

	typedef enum logic [2:0] {
		MODE_SLOW = 3'd0,
		MODE_MID  = 3'd1,
		MODE_FAST = 3'd2,
		MODE_OFF  = 3'd3,
		MODE_ON   = 3'd4,
		MODE_WAIT = 3'd5
	} mode_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] slow;
		logic [INTERVAL_W-1:0] mid;
		logic [INTERVAL_W-1:0] fast;
		logic [SECRET_W-1:0]   secret;
	} cfg_t;

	typedef struct packed {
		mode_t                       mode;
		logic                        ret;
		logic                        led;
		logic                        phase;
		logic [INTERVAL_W-1:0]       elapsed;
		logic [CODE_LENGTH-1:0][1:0] keys;
		logic [KCNT_W-1:0]           kcnt;
		logic                        pend_valid;
		logic [1:0]                  pend_button;
	} state_t;

	typedef struct packed {
		mode_t mode;
		logic  led_level;
	} res_t;

	// status of the result buffer
	typedef struct packed {
		logic out_valid;
		logic skid_valid;
	} obuf_stat_t;

endpackage

// ----- rtl/core/blink_mode_controller_with_code_lock.sv -----
// ----------------------------------------------------------------------------
// blink_mode_controller_with_code_lock
// LED mode controller with blink timing and a button code lock.
// Each accepted word's result is registered in the output or skid register.
// Throughput: one word per cycle while s_tready is high (skid entry empty).
// A two-entry result buffer keeps s_tready high while one result waits.
// Reset (arst_n low) restores registers, mode, LED and buffers at once.
// ----------------------------------------------------------------------------
module blink_mode_controller_with_code_lock
	import blmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [1:0] button, [7:2] zero
	input  logic                  s_tuser,   // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [0] led_level, [3:1] mode, [7:4] zero
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [INTERVAL_W-1:0] cfg_wdata
);

	cfg_t       cfg_q;
	state_t     st_q;
	state_t     st_nx;
	obuf_stat_t ob_stat;
	res_t       res_nx;
	res_t       res_out;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow   <= SLOW_RESET;
			cfg_q.mid    <= MID_RESET;
			cfg_q.fast   <= FAST_RESET;
			cfg_q.secret <= SECRET_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SLOW:   cfg_q.slow   <= cfg_wdata;
				REG_MID:    cfg_q.mid    <= cfg_wdata;
				REG_FAST:   cfg_q.fast   <= cfg_wdata;
				REG_SECRET: cfg_q.secret <= cfg_wdata[SECRET_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	assign s_tready = !ob_stat.skid_valid;
	assign accept   = s_tvalid && s_tready;

	blmc_step u_step (
		.st      (st_q),
		.cfg     (cfg_q),
		.command (s_tuser),
		.button  (s_tdata[1:0]),
		.st_nx   (st_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode        <= MODE_SLOW;
			st_q.ret         <= RET_OFF;
			st_q.led         <= 1'b1;
			st_q.phase       <= 1'b0;
			st_q.elapsed     <= '0;
			st_q.keys        <= '0;
			st_q.kcnt        <= '0;
			st_q.pend_valid  <= 1'b0;
			st_q.pend_button <= '0;
		end else if (accept) begin
			st_q <= st_nx;
		end
	end

	assign res_nx.mode      = st_nx.mode;
	assign res_nx.led_level = st_nx.led;

	blmc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_nx),
		.pop_ready (m_tready),
		.out_data  (res_out),
		.stat      (ob_stat)
	);

	assign m_tvalid = ob_stat.out_valid;
	assign m_tdata  = {4'b0000, res_out.mode, res_out.led_level};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		ob_stat.skid_valid |-> ob_stat.out_valid)
		else $error("skid entry held without an output entry");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ob_stat.skid_valid && !m_tready) |=> ob_stat.skid_valid)
		else $error("skid entry lost while stalled");

	a_kcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.kcnt < KCNT_W'(CODE_LENGTH))
		else $error("key count out of range");

	a_off_led: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_OFF) |-> !st_q.led)
		else $error("LED lit in off mode");

	a_on_led: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_ON) |-> st_q.led)
		else $error("LED dark in on mode");

endmodule

// ----- rtl/core/blmc_step.sv -----
// ----------------------------------------------------------------------------
// blmc_step
// Next-state logic for one word: tick/press bookkeeping, blinking, code lock.
// ----------------------------------------------------------------------------
module blmc_step
	import blmc_pkg::*;
(
	input  state_t     st,
	input  cfg_t       cfg,
	input  logic       command,
	input  logic [1:0] button,
	output state_t     st_nx
);

	logic [INTERVAL_W-1:0]       elapsed1;
	logic                        blink_mode;
	logic [INTERVAL_W-1:0]       blink_iv;
	logic                        do_toggle;
	logic [1:0]                  pend_b1;
	logic [SECRET_EXT_W-1:0]     secret_ext;
	logic [CODE_LENGTH-1:0][1:0] keys_nx;
	logic [KCNT_W-1:0]           kcnt_inc;
	logic                        code_ok;
	state_t                      st_mode;

	always_comb begin
		elapsed1 = st.elapsed;
		if (command == CMD_TICK && st.elapsed != ELAPSED_MAX)
			elapsed1 = st.elapsed + 1'b1;
	end

	always_comb begin
		blink_mode = 1'b1;
		case (st.mode)
			MODE_SLOW: blink_iv = cfg.slow;
			MODE_MID:  blink_iv = cfg.mid;
			MODE_FAST: blink_iv = cfg.fast;
			default: begin
				blink_iv   = cfg.slow;
				blink_mode = 1'b0;
			end
		endcase
	end

	assign do_toggle = blink_mode && (elapsed1 >= blink_iv);

	// pending button as seen after this word's event
	assign pend_b1 = (command != CMD_TICK) ? button : st.pend_button;

	// key buffer write and compare against the secret, zero beyond its width
	assign secret_ext = SECRET_EXT_W'(cfg.secret);
	assign kcnt_inc   = st.kcnt + 1'b1;

	always_comb begin
		keys_nx = st.keys;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (st.kcnt == KCNT_W'(i))
				keys_nx[i] = pend_b1;
		end
	end

	always_comb begin
		code_ok = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (keys_nx[i] != secret_ext[2*i +: 2])
				code_ok = 1'b0;
		end
	end

	// next mode and bookkeeping
	always_comb begin
		st_mode         = st;
		st_mode.elapsed = elapsed1;
		if (command != CMD_TICK) begin
			st_mode.pend_valid  = 1'b1;
			st_mode.pend_button = button;
		end
		if (do_toggle) begin
			st_mode.led     = st.phase;
			st_mode.phase   = ~st.phase;
			st_mode.elapsed = '0;
		end
		case (st.mode)
			MODE_SLOW: begin
				if (st_mode.pend_valid) begin
					st_mode.pend_valid = 1'b0;
					if (st_mode.pend_button == BTN_ONE)
						st_mode.mode = MODE_WAIT;
					else if (st_mode.pend_button == BTN_TWO)
						st_mode.mode = MODE_MID;
				end
			end
			MODE_MID: begin
				if (st_mode.pend_valid) begin
					st_mode.pend_valid = 1'b0;
					if (st_mode.pend_button == BTN_ONE)
						st_mode.mode = MODE_ON;
					else if (st_mode.pend_button == BTN_TWO)
						st_mode.mode = MODE_SLOW;
				end
			end
			MODE_FAST: begin
				if (st_mode.pend_valid) begin
					st_mode.pend_valid = 1'b0;
					st_mode.keys       = keys_nx;
					if (kcnt_inc >= KCNT_W'(CODE_LENGTH)) begin
						st_mode.kcnt = '0;
						if (code_ok)
							st_mode.mode = (st.ret == RET_ON) ? MODE_ON : MODE_OFF;
					end else begin
						st_mode.kcnt = kcnt_inc;
					end
				end
			end
			MODE_WAIT: begin
				if (elapsed1 >= cfg.slow)
					st_mode.mode = MODE_OFF;
			end
			MODE_OFF: begin
				if (st_mode.pend_valid) begin
					st_mode.pend_valid = 1'b0;
					if (st_mode.pend_button == BTN_ONE) begin
						st_mode.mode = MODE_SLOW;
						st_mode.ret  = RET_OFF;
					end else if (st_mode.pend_button == BTN_TWO) begin
						st_mode.mode = MODE_FAST;
						st_mode.ret  = RET_OFF;
					end
				end
			end
			MODE_ON: begin
				if (st_mode.pend_valid) begin
					st_mode.pend_valid = 1'b0;
					if (st_mode.pend_button == BTN_ONE) begin
						st_mode.mode = MODE_MID;
					end else if (st_mode.pend_button == BTN_TWO) begin
						st_mode.mode = MODE_FAST;
						st_mode.ret  = RET_ON;
					end
				end
			end
			default: st_mode.mode = MODE_SLOW;
		endcase
	end

	// steady modes drive the LED level directly
	always_comb begin
		st_nx = st_mode;
		case (st_mode.mode)
			MODE_OFF: st_nx.led = 1'b0;
			MODE_ON:  st_nx.led = 1'b1;
			default:  st_nx.led = st_mode.led;
		endcase
	end

endmodule

// ----- rtl/core/blmc_obuf.sv -----
// ----------------------------------------------------------------------------
// blmc_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module blmc_obuf
	import blmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  res_t       push_data,
	input  logic       pop_ready,
	output res_t       out_data,
	output obuf_stat_t stat
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop = out_valid_q && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop)
				skid_q <= push_data;
			else
				out_q <= push_data;
		end
	end

	assign out_data        = out_q;
	assign stat.out_valid  = out_valid_q;
	assign stat.skid_valid = skid_valid_q;

endmodule
